// File: design/integer_stack_engine_macros.svh
// Assertion macros for the integer stack engine.
// Depends on nothing; expects i_clk and i_rst_n in the including scope.
`ifndef INTEGER_STACK_ENGINE_MACROS_SVH
`define INTEGER_STACK_ENGINE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define ISE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define ISE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ise_pkg.sv
// Shared types and codes for the integer stack engine.
// No dependencies.
package ise_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int ERR_W  = 3;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DUMP = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SWAP = 3'd4;

    // Status codes
    localparam logic [ERR_W-1:0] ERR_OK         = 3'd0;
    localparam logic [ERR_W-1:0] ERR_PEEK_EMPTY = 3'd1;
    localparam logic [ERR_W-1:0] ERR_POP_EMPTY  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_SWAP_SHORT = 3'd3;
    localparam logic [ERR_W-1:0] ERR_PUSH_FULL  = 3'd4;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEEK,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_SWAP_C,
        ST_DUMP
    } t_state;

endpackage

// File: design/integer_stack_engine.sv
// Integer stack engine: bounded LIFO of signed 32-bit entries in one RAM.
// Depends on ise_pkg and integer_stack_engine_macros.svh.
//
// A command is taken when start is high and busy is low. Results appear on the
// o_ ports for a single cycle, flagged by o_result_strobe, and must be taken
// then: there is no back-pressure. Push, pop, unused codes and every error give
// their result the cycle after the command and leave busy low, so a command can
// follow in every cycle. Peek holds busy while in ST_PEEK, swap while in ST_SWAP_A,
// ST_SWAP_B and ST_SWAP_C, and a dump while in ST_DUMP, giving one entry per
// cycle, top first, last flagged; a dump of an empty stack gives no result.
// These busy states follow from the single registered read port and single
// write port of the stack RAM.
module integer_stack_engine #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ise_pkg::CMD_W-1:0]         i_command,
    input  logic signed [ise_pkg::DATA_W-1:0] i_push_value,
    output logic                              o_result_strobe,
    output logic signed [ise_pkg::DATA_W-1:0] o_data_value,
    output logic                              o_data_valid,
    output logic [ise_pkg::ERR_W-1:0]         o_error_code,
    output logic                              o_last_result
);

    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

    // Stack RAM
    logic signed [ise_pkg::DATA_W-1:0] mem [STACK_DEPTH];
    logic signed [ise_pkg::DATA_W-1:0] r_rdata;

    logic                              mem_we;
    logic [IDX_W-1:0]                  mem_waddr;
    logic signed [ise_pkg::DATA_W-1:0] mem_wdata;
    logic                              mem_re;
    logic [IDX_W-1:0]                  mem_raddr;

    // Control and result registers
    ise_pkg::t_state                   r_state, n_state;
    logic [CNT_W-1:0]                  r_count, n_count;
    logic [IDX_W-1:0]                  r_ptr, n_ptr;
    logic signed [ise_pkg::DATA_W-1:0] r_hold, n_hold;
    logic                              r_strobe, n_strobe;
    logic signed [ise_pkg::DATA_W-1:0] r_data, n_data;
    logic                              r_valid, n_valid;
    logic [ise_pkg::ERR_W-1:0]         r_err, n_err;
    logic                              r_last, n_last;

    // Top and second entry addresses
    logic [CNT_W-1:0] count_m1, count_m2;
    logic [IDX_W-1:0] top_idx, below_idx;
    logic [IDX_W-1:0] ptr_m1;

    assign count_m1  = r_count - CNT_W'(1);
    assign count_m2  = r_count - CNT_W'(2);
    assign top_idx   = count_m1[IDX_W-1:0];
    assign below_idx = count_m2[IDX_W-1:0];
    assign ptr_m1    = r_ptr - IDX_W'(1);

    // RAM write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // RAM read port, registered
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ise_pkg::ST_IDLE;
            r_count  <= '0;
            r_ptr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ptr    <= n_ptr;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_hold  <= n_hold;
        r_data  <= n_data;
        r_valid <= n_valid;
        r_err   <= n_err;
        r_last  <= n_last;
    end

    // Sequencer: next state, RAM accesses and result
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_hold    = r_hold;
        n_strobe  = 1'b0;
        n_data    = '0;
        n_valid   = 1'b0;
        n_err     = ise_pkg::ERR_OK;
        n_last    = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = r_count[IDX_W-1:0];
        mem_wdata = i_push_value;
        mem_re    = 1'b0;
        mem_raddr = top_idx;

        case (r_state)
            ise_pkg::ST_IDLE: begin
                if (start) begin
                    case (i_command)
                        ise_pkg::CMD_PUSH: begin
                            n_strobe = 1'b1;
                            if (r_count == FULL_CNT) begin
                                n_err = ise_pkg::ERR_PUSH_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        ise_pkg::CMD_DUMP: begin
                            // empty stack: nothing emitted
                            if (r_count != '0) begin
                                mem_re  = 1'b1;
                                n_ptr   = top_idx;
                                n_state = ise_pkg::ST_DUMP;
                            end
                        end
                        ise_pkg::CMD_PEEK: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_err    = ise_pkg::ERR_PEEK_EMPTY;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = ise_pkg::ST_PEEK;
                            end
                        end
                        ise_pkg::CMD_POP: begin
                            n_strobe = 1'b1;
                            if (r_count == '0) begin
                                n_err = ise_pkg::ERR_POP_EMPTY;
                            end else begin
                                n_count = count_m1;
                            end
                        end
                        ise_pkg::CMD_SWAP: begin
                            if (r_count < CNT_W'(2)) begin
                                n_strobe = 1'b1;
                                n_err    = ise_pkg::ERR_SWAP_SHORT;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = ise_pkg::ST_SWAP_A;
                            end
                        end
                        default: begin
                            // unused code: plain ok status
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            ise_pkg::ST_PEEK: begin
                n_strobe = 1'b1;
                n_data   = r_rdata;
                n_valid  = 1'b1;
                n_state  = ise_pkg::ST_IDLE;
            end
            ise_pkg::ST_SWAP_A: begin
                // top is in; fetch the entry below it
                n_hold    = r_rdata;
                mem_re    = 1'b1;
                mem_raddr = below_idx;
                n_state   = ise_pkg::ST_SWAP_B;
            end
            ise_pkg::ST_SWAP_B: begin
                mem_we    = 1'b1;
                mem_waddr = top_idx;
                mem_wdata = r_rdata;
                n_state   = ise_pkg::ST_SWAP_C;
            end
            ise_pkg::ST_SWAP_C: begin
                mem_we    = 1'b1;
                mem_waddr = below_idx;
                mem_wdata = r_hold;
                n_strobe  = 1'b1;
                n_state   = ise_pkg::ST_IDLE;
            end
            ise_pkg::ST_DUMP: begin
                // emit current entry, fetch the next one down
                n_strobe = 1'b1;
                n_data   = r_rdata;
                n_valid  = 1'b1;
                n_last   = (r_ptr == '0);
                if (r_ptr != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_m1;
                    n_ptr     = ptr_m1;
                end else begin
                    n_state = ise_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ise_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    assign busy            = (r_state != ise_pkg::ST_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_data_value    = r_data;
    assign o_data_valid    = r_valid;
    assign o_error_code    = r_err;
    assign o_last_result   = r_last;

    // Checks
`include "integer_stack_engine_macros.svh"

    `ISE_ASSERT_NOW(a_count_bound, 1'b1, r_count <= FULL_CNT, "entry count beyond stack depth")
    `ISE_ASSERT_NOW(a_partial_in_dump, o_result_strobe && !o_last_result, r_state == ise_pkg::ST_DUMP, "non-final result outside a dump")
    `ISE_ASSERT_NEXT(a_push_grows, start && !busy && i_command == ise_pkg::CMD_PUSH && r_count != FULL_CNT, r_count == $past(r_count) + CNT_W'(1), "push did not grow the stack")

endmodule

// File: tb/ise_checker.sv
`timescale 1ns / 1ps
// Result checker for the integer stack engine: watches the command and result ports.
// Depends on ise_pkg; keeps its own stack model and a queue of predicted results.
module ise_checker #(
    parameter int DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [ise_pkg::CMD_W-1:0]         i_command,
    input  logic signed [ise_pkg::DATA_W-1:0] i_push_value,
    input  logic                              o_result_strobe,
    input  logic signed [ise_pkg::DATA_W-1:0] o_data_value,
    input  logic                              o_data_valid,
    input  logic [ise_pkg::ERR_W-1:0]         o_error_code,
    input  logic                              o_last_result,
    output int                                fail_count,
    output int                                pending_count
);

    localparam int DATA_W = ise_pkg::DATA_W;

    typedef struct packed {
        logic signed [ise_pkg::DATA_W-1:0] data_value;
        logic                              data_valid;
        logic [ise_pkg::ERR_W-1:0]         error_code;
        logic                              last_result;
    } t_stack_result;

    // Shadow of the stack contents and fill level
    logic signed [DATA_W-1:0] stack_model [DEPTH];
    int                       depth_used;
    t_stack_result            expected_results [$];
    t_stack_result            oldest;

    initial begin
        fail_count    = 0;
        pending_count = 0;
        depth_used    = 0;
    end

    // Work out the results of one accepted command and queue them
    task automatic predict_command(input logic [ise_pkg::CMD_W-1:0] cmd,
                                   input logic signed [DATA_W-1:0] val);
        t_stack_result            r;
        logic signed [DATA_W-1:0] tmp;
        r = '{data_value: '0, data_valid: 1'b0, error_code: ise_pkg::ERR_OK,
              last_result: 1'b1};
        case (cmd)
            ise_pkg::CMD_PUSH: begin
                if (depth_used >= DEPTH) begin
                    r.error_code = ise_pkg::ERR_PUSH_FULL;
                end else begin
                    stack_model[depth_used] = val;
                    depth_used++;
                end
            end
            ise_pkg::CMD_DUMP: begin
                // top first, last entry flagged; nothing at all when empty
                for (int k = depth_used - 1; k >= 0; k--) begin
                    r.data_value  = stack_model[k];
                    r.data_valid  = 1'b1;
                    r.last_result = (k == 0);
                    expected_results.push_back(r);
                end
                return;
            end
            ise_pkg::CMD_PEEK: begin
                if (depth_used == 0) begin
                    r.error_code = ise_pkg::ERR_PEEK_EMPTY;
                end else begin
                    r.data_value = stack_model[depth_used - 1];
                    r.data_valid = 1'b1;
                end
            end
            ise_pkg::CMD_POP: begin
                if (depth_used == 0) r.error_code = ise_pkg::ERR_POP_EMPTY;
                else depth_used--;
            end
            ise_pkg::CMD_SWAP: begin
                if (depth_used < 2) begin
                    r.error_code = ise_pkg::ERR_SWAP_SHORT;
                end else begin
                    tmp                         = stack_model[depth_used - 1];
                    stack_model[depth_used - 1] = stack_model[depth_used - 2];
                    stack_model[depth_used - 2] = tmp;
                end
            end
            default: ; // spare codes: plain OK status
        endcase
        expected_results.push_back(r);
    endtask

    task automatic report_field(input string name, input logic [DATA_W-1:0] exp_v,
                                input logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Compare each strobed result with the oldest prediction, then log new items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            depth_used = 0;
            expected_results.delete();
        end else begin
            if (o_result_strobe) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h %b %0d %b",
                             $time, o_data_value, o_data_valid, o_error_code, o_last_result);
                    fail_count++;
                end else begin
                    oldest = expected_results.pop_front();
                    report_field("data_value", oldest.data_value, o_data_value);
                    report_field("data_valid", DATA_W'(oldest.data_valid),
                                 DATA_W'(o_data_valid));
                    report_field("error_code", DATA_W'(oldest.error_code),
                                 DATA_W'(o_error_code));
                    report_field("last_result", DATA_W'(oldest.last_result),
                                 DATA_W'(o_last_result));
                end
            end
            if (start && !busy) predict_command(i_command, i_push_value);
        end
        pending_count = expected_results.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the integer stack engine testbench: clock, reset, command stimulus, verdict.
// Depends on ise_pkg, integer_stack_engine and ise_checker.
module tb_top;

    localparam int STACK_DEPTH = 64;
    localparam int RANDOM_ITEMS = 12;
    localparam int CMD_W = ise_pkg::CMD_W;
    localparam int DATA_W = ise_pkg::DATA_W;

    logic                              i_clk;
    logic                              i_rst_n      = 1'b0;
    logic                              start        = 1'b0;
    logic [CMD_W-1:0]                  i_command    = '0;
    logic signed [DATA_W-1:0]          i_push_value = '0;
    logic                              busy;
    logic                              o_result_strobe;
    logic signed [DATA_W-1:0]          o_data_value;
    logic                              o_data_valid;
    logic [ise_pkg::ERR_W-1:0]         o_error_code;
    logic                              o_last_result;
    int                                fail_count;
    int                                pending_count;
    bit                                gaps_on = 1'b1;
    int                                pick;

    integer_stack_engine #(.STACK_DEPTH(STACK_DEPTH)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_push_value    (i_push_value),
        .o_result_strobe (o_result_strobe),
        .o_data_value    (o_data_value),
        .o_data_valid    (o_data_valid),
        .o_error_code    (o_error_code),
        .o_last_result   (o_last_result)
    );

    ise_checker #(.DEPTH(STACK_DEPTH)) checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_push_value    (i_push_value),
        .o_result_strobe (o_result_strobe),
        .o_data_value    (o_data_value),
        .o_data_valid    (o_data_valid),
        .o_error_code    (o_error_code),
        .o_last_result   (o_last_result),
        .fail_count      (fail_count),
        .pending_count   (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or results go missing
    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    // Random words half the time, otherwise one of the extremes
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return {1'b0, {(DATA_W-1){1'b1}}};
            1:       return {1'b1, {(DATA_W-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Present one item and hold it until start meets a low busy
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val);
        if (gaps_on) begin
            while ($urandom_range(99) < 13) begin
                start     <= 1'b0;
                i_command <= CMD_W'($urandom);
                @(posedge i_clk);
            end
        end
        start        <= 1'b1;
        i_command    <= cmd;
        i_push_value <= val;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-stack errors, spare codes, extremes, one-entry swap
        send_command(ise_pkg::CMD_PEEK, $urandom);
        send_command(ise_pkg::CMD_POP, $urandom);
        send_command(ise_pkg::CMD_SWAP, $urandom);
        send_command(ise_pkg::CMD_DUMP, $urandom);
        for (int c = int'(ise_pkg::CMD_SWAP) + 1; c < (1 << CMD_W); c++)
            send_command(CMD_W'(c), $urandom);
        send_command(ise_pkg::CMD_PUSH, {1'b0, {(DATA_W-1){1'b1}}});
        send_command(ise_pkg::CMD_SWAP, $urandom);
        send_command(ise_pkg::CMD_PEEK, $urandom);
        send_command(ise_pkg::CMD_PUSH, {1'b1, {(DATA_W-1){1'b0}}});
        send_command(ise_pkg::CMD_PUSH, '0);
        send_command(ise_pkg::CMD_PUSH, '1);
        send_command(ise_pkg::CMD_DUMP, $urandom);
        send_command(ise_pkg::CMD_SWAP, $urandom);
        send_command(ise_pkg::CMD_PEEK, $urandom);
        send_command(ise_pkg::CMD_DUMP, $urandom);
        repeat (2) begin
            send_command(ise_pkg::CMD_POP, $urandom);
            send_command(ise_pkg::CMD_PEEK, $urandom);
        end
        repeat (3) send_command(ise_pkg::CMD_POP, $urandom);

        // Random: push-leaning mix, with one fill past full run with no idling
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 4) begin
                gaps_on = 1'b0;
                repeat (STACK_DEPTH + 1) send_command(ise_pkg::CMD_PUSH, pick_value());
                send_command(ise_pkg::CMD_PEEK, $urandom);
                send_command(ise_pkg::CMD_SWAP, $urandom);
                send_command(ise_pkg::CMD_DUMP, $urandom);
                gaps_on = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 40)      send_command(ise_pkg::CMD_PUSH, pick_value());
            else if (pick < 48) send_command(ise_pkg::CMD_DUMP, $urandom);
            else if (pick < 63) send_command(ise_pkg::CMD_PEEK, $urandom);
            else if (pick < 83) send_command(ise_pkg::CMD_POP, $urandom);
            else if (pick < 95) send_command(ise_pkg::CMD_SWAP, $urandom);
            else send_command(CMD_W'($urandom_range((1 << CMD_W) - 1,
                                                    int'(ise_pkg::CMD_SWAP) + 1)),
                              $urandom);
        end
        send_command(ise_pkg::CMD_DUMP, $urandom);
        start <= 1'b0;

        // Drain: every prediction met, then allow for a full dump in flight
        wait (pending_count == 0);
        repeat (STACK_DEPTH + 8) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
